FILE: sv/vnu_pkg.sv
package vnu_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int ELEM_W      = 16;
   localparam int MAG_W       = ELEM_W + 1;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int ACC_W       = 41;
   localparam int CNT_W       = $clog2(MAX_LEN + 2);
   localparam int MODE_W      = 2;
   localparam int NORM_W      = 26;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SQRT_STEPS  = (ACC_W + 1) / 2;
   localparam int STEP_W      = $clog2(SQRT_STEPS);

   localparam logic [ACC_W-1:0]  ACC_MAX     = '1;
   localparam logic [ACC_W-1:0]  NORM_MAX    = ACC_W'(33554432);
   localparam logic [ACC_W-1:0]  SQRT_BIT0   = ACC_W'(1) << (2 * (SQRT_STEPS - 1));
   localparam logic [CNT_W-1:0]  MAX_LEN_CNT = CNT_W'(MAX_LEN);
   localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(SQRT_STEPS - 1);

   localparam logic [MODE_W-1:0] MODE_L1   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_L2   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LINF = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_NORM_MODE = 3'd0;

   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [MODE_W-1:0] mode;
      logic              over;
   } job_type;

endpackage

FILE: sv/vnu_front.sv
module vnu_front import vnu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] mode,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ELEM_W-1:0] req_tdata,   // [15:0] element
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job
);

   logic [ACC_W-1:0] acc_ff, acc_in, acc_upd;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_upd;
   logic [MAG_W-1:0] mag;
   logic [SQ_W-1:0]  sq;
   logic [ACC_W:0]   sum;
   logic [ACC_W-1:0] addend;
   logic             take;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   assign mag = req_tdata[ELEM_W-1] ? MAG_W'({1'b1, {ELEM_W{1'b0}}} - {1'b0, req_tdata})
                                    : {1'b0, req_tdata};
   assign sq  = mag * mag;

   always_comb begin
      addend = (mode == MODE_L2) ? ACC_W'(sq) : ACC_W'(mag);
      sum    = {1'b0, acc_ff} + {1'b0, addend};
      acc_upd = acc_ff;
      if (cnt_ff < MAX_LEN_CNT) begin
         unique case (mode)
            MODE_L1, MODE_L2: acc_upd = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            MODE_LINF:        acc_upd = (ACC_W'(mag) > acc_ff) ? ACC_W'(mag) : acc_ff;
            default:          acc_upd = acc_ff;
         endcase
      end
      cnt_upd = (cnt_ff <= MAX_LEN_CNT) ? cnt_ff + 1'b1 : cnt_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (take) begin
         acc_in = req_tlast ? '0 : acc_upd;
         cnt_in = req_tlast ? '0 : cnt_upd;
      end
   end

   assign q_push    = take && req_tlast;
   assign q_job.acc  = acc_upd;
   assign q_job.mode = mode;
   assign q_job.over = cnt_upd > MAX_LEN_CNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sv/vnu_queue.sv
module vnu_queue import vnu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   // depth is a power of two: pointers wrap by overflow
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/vnu_back.sv
module vnu_back import vnu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  job_type               head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [25:0] norm, [26] overflow
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SQRT = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [ACC_W-1:0]   v_ff, v_in, bit_ff, bit_in;
   logic [ACC_W:0]     res_ff, res_in, trial;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               over_ff, over_in;
   logic               valid_ff, valid_in;
   logic [NORM_W-1:0]  norm_ff, norm_in;
   logic               ovf_ff, ovf_in;
   logic               out_free, load;
   logic [ACC_W-1:0]   src_norm;
   logic               src_over;

   assign out_free = !valid_ff || rsp_tready;
   assign trial    = res_ff + {1'b0, bit_ff};

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      over_in  = over_ff;
      pop      = 1'b0;
      load     = 1'b0;
      src_norm = '0;
      src_over = over_ff;
      unique case (state_ff)
         ST_IDLE: begin
            src_over = head_job.over;
            if (head_job.mode == MODE_L1 || head_job.mode == MODE_LINF)
               src_norm = head_job.acc;
            if (head_valid && head_job.mode == MODE_L2) begin
               pop      = 1'b1;
               v_in     = head_job.acc;
               res_in   = '0;
               bit_in   = SQRT_BIT0;
               step_in  = '0;
               over_in  = head_job.over;
               state_in = ST_SQRT;
            end else if (head_valid && out_free) begin
               pop  = 1'b1;
               load = 1'b1;
            end
         end
         ST_SQRT: begin
            if ({1'b0, v_ff} >= trial) begin
               v_in   = v_ff - trial[ACC_W-1:0];
               res_in = (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (step_ff == LAST_STEP)
               state_in = ST_FIN;
            else
               step_in = step_ff + 1'b1;
         end
         ST_FIN: begin
            src_norm = res_ff[ACC_W-1:0];
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      norm_in  = norm_ff;
      ovf_in   = ovf_ff;
      if (load) begin
         valid_in = 1'b1;
         if (src_over || src_norm > NORM_MAX) begin
            norm_in = NORM_MAX[NORM_W-1:0];
            ovf_in  = 1'b1;
         end else begin
            norm_in = src_norm[NORM_W-1:0];
            ovf_in  = 1'b0;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - NORM_W - 1){1'b0}}, ovf_ff, norm_ff};

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      over_ff <= over_in;
      norm_ff <= norm_in;
      ovf_ff  <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: sv/vector_norm_unit.sv
// Streaming vector norm, Q8.8 fixed point.
// Input stream req_*: one signed Q8.8 element per transfer, req_tlast on the
// final element of a vector. Result stream rsp_*: one transfer per vector with
// the norm (unsigned Q18.8) and an overflow flag.
// Register norm_mode at csr address 0: 0 sum of magnitudes, 1 Euclidean,
// 2 largest magnitude. Write it only between vectors.
// The front end takes one element every cycle while the queue is not full, one
// add or compare each, and hands each finished vector to a two-entry queue.
// The back end turns the queue head into a result, registered onto rsp_tvalid:
// modes 0 and 2 load it directly, the Euclidean norm first runs the 21-step
// iterative square root and its finish state. Elements keep flowing while the
// back end works until the queue is full, then req_tready drops.
// A stalled result holds in the output register; the back end waits, though
// it may still run a Euclidean vector through the square root, and the queue
// absorbs up to two more vectors.
// Reset clears the accumulator, the element count, the queue and the result
// valid, and sets norm_mode to 0. More than 1024 elements saturate the norm.
module vector_norm_unit import vnu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ELEM_W-1:0]     req_tdata,    // [15:0] element
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [25:0] norm, [26] overflow
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              q_full, q_push, q_pop, q_valid;
   job_type           q_job, q_head;

   assign csr_pready = 1'b1;
   assign mode_in = (csr_psel && csr_penable && csr_pwrite && csr_pready
                     && csr_paddr[CSR_ADDR_W-1] == REG_NORM_MODE[CSR_ADDR_W-1])
                    ? csr_pwdata[MODE_W-1:0] : mode_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_NORM_MODE[CSR_ADDR_W-1])
                       ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset)
         mode_ff <= MODE_L1;
      else
         mode_ff <= mode_in;
   end

   vnu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_job)
   );

   vnu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   vnu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_job   (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/vnu_checker.sv
module vnu_checker import vnu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[NORM_W-1:0] <= NORM_MAX[NORM_W-1:0])
      else $error("norm above saturation limit");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[NORM_W] |-> rsp_tdata[NORM_W-1:0] == NORM_MAX[NORM_W-1:0])
      else $error("overflow without saturated norm");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind vector_norm_unit vnu_checker u_vnu_checker (.*);
